>>> hw/rtl/lln_pkg.sv
// Shared constants, types and the sigmoid lookup table of the logistic-loss Newton step unit.
package lln_pkg;

    localparam int TARGET_COUNT = 8;
    localparam int SIGMOID_TABLE_BITS = 8;
    localparam int TABLE_SIZE = 1 << SIGMOID_TABLE_BITS;
    localparam int TGT_W = 3;
    localparam int ADDR_W = (TARGET_COUNT > 1) ? $clog2(TARGET_COUNT) : 1;
    localparam int SUM_W = 64;
    localparam int ONE_Q15 = 32768;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MIN = -65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] RATE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] RATE_MIN = 32'h8000_0000;

    typedef logic [15:0] sig_table_t [TABLE_SIZE];

    typedef struct packed {
        logic        start;
        logic signed [63:0] grad;
        logic [62:0] curv;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] rate;
    } div_rsp_t;

    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_neg_q30(input logic [63:0] y);
        logic signed [63:0] sum;
        logic [63:0] term;
        sum = signed'(ONE_Q30);
        term = ONE_Q30;
        for (int k = 1; k <= 20; k++) begin
            term = udiv64((term * y) >> 30, 64'(k));
            if ((k % 2) == 1) begin
                sum = sum - signed'(term);
            end
            else begin
                sum = sum + signed'(term);
            end
        end
        return (sum < 0) ? 64'd0 : unsigned'(sum);
    endfunction

    function automatic sig_table_t build_sig_table();
        sig_table_t tab;
        logic [63:0] e1;
        logic [63:0] r;
        logic [63:0] den;
        logic [63:0] sp;
        int m;
        int a;
        int n;
        e1 = exp_neg_q30(ONE_Q30);
        for (int t = 0; t < TABLE_SIZE; t++) begin
            m = ((2 * t + 1) << (15 - SIGMOID_TABLE_BITS)) - 32768;
            a = (m < 0) ? -m : m;
            n = a >> 12;
            r = exp_neg_q30(64'(a & 4095) << 18);
            for (int i = 0; i < n; i++) begin
                r = (r * e1) >> 30;
            end
            den = ONE_Q30 + r;
            sp = udiv64((64'd1 << 45) + (den >> 1), den);
            tab[t] = (m > 0) ? sp[15:0] : 16'(64'(ONE_Q15) - sp);
        end
        return tab;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

>>> hw/rtl/lln_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lln_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/lln_div.sv
// Bit-serial divider that forms the saturated signed Q4.28 Newton step from the two sums.
module lln_div
    import lln_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    typedef enum logic [1:0] {D_IDLE, D_CHECK, D_ITER} dstate_t;

    dstate_t     state_reg;
    logic        neg_reg;
    logic [62:0] mag_reg;
    logic [64:0] dvs_reg;
    logic [65:0] rem_reg;
    logic [29:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic        done_reg;
    logic [31:0] rate_reg;

    logic [63:0] gabs;
    logic        ge;
    logic [65:0] rem_next;

    assign gabs = req.grad[63] ? 64'(-req.grad) : 64'(req.grad);
    assign ge = rem_reg >= {1'b0, dvs_reg};
    assign rem_next = ge ? ((rem_reg - {1'b0, dvs_reg}) << 1) : (rem_reg << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        neg_reg <= !req.grad[63] && (req.grad != '0);
                        mag_reg <= gabs[62:0];
                        dvs_reg <= {req.curv, 2'b00};
                        if (req.curv == '0)
                        begin
                            rate_reg <= '0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= D_CHECK;
                        end
                    end
                end
                D_CHECK:
                begin
                    if ({3'b000, mag_reg} >= {dvs_reg, 1'b0})
                    begin
                        rate_reg  <= neg_reg ? RATE_MIN : RATE_MAX;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        rem_reg   <= {3'b000, mag_reg};
                        cnt_reg   <= 5'd30;
                        state_reg <= D_ITER;
                    end
                end
                D_ITER:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[28:0], ge};
                    if (cnt_reg == '0)
                    begin
                        rate_reg  <= neg_reg ? 32'(-{1'b0, quo_reg, ge})
                                             : {1'b0, quo_reg, ge};
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rate = rate_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == D_IDLE)
        else $error("divider started while busy");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == D_ITER |-> cnt_reg <= 5'd30)
        else $error("divider count out of range");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == D_ITER |-> rem_reg < {dvs_reg, 1'b0})
        else $error("divider remainder out of bound");

endmodule

>>> hw/rtl/logistic_loss_newton_step_unit.sv
// Top level of the logistic-loss Newton step unit.
// Each row takes the sigmoid of the old score from a table, returns target minus sigmoid and
// folds the gradient and curvature terms into per-target sums held in two small RAMs. A row
// passes through the table lookup and RAM read, two multiply stages, the saturating
// accumulate and write-back, and the output load; a row marked last also waits in the
// bit-serial divider that forms the Q4.28 step, and its write-back clears the sums of
// that target. Sums read as zero after reset until first written. A new row may be taken
// while the previous result still waits in the output register.
module logistic_loss_newton_step_unit
    import lln_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // target_index[2:0], old_score[18:3], target_value[34:19], new_prediction[50:35]
    input  logic [55:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // residual[16:0], result_target[19:17], update_rate[51:20]
    output logic [55:0] m_tdata,
    // rate_valid[0]
    output logic        m_tuser
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_MUL2, S_ACC, S_DIV, S_OUT} state_t;

    state_t state_reg;
    logic [TGT_W-1:0]   tgt_reg;
    logic               last_reg;
    logic               tgt_ok_reg;
    logic signed [16:0] s_reg;
    logic signed [16:0] y_reg;
    logic signed [15:0] p_reg;
    logic signed [63:0] gold_reg;
    logic [63:0]        hold_reg;
    logic signed [32:0] gterm_reg;
    logic [30:0]        pp_reg;
    logic [14:0]        hs_reg;
    logic [45:0]        hterm_reg;
    logic [TARGET_COUNT-1:0] valid_reg;
    logic [31:0]        rate_reg;
    logic               rvalid_reg;
    logic               out_valid_reg;
    logic [16:0]        res_out_reg;
    logic [TGT_W-1:0]   tgt_out_reg;
    logic               rvalid_out_reg;
    logic [31:0]        rate_out_reg;

    logic               accept;
    logic [TGT_W-1:0]   in_tgt;
    logic [15:0]        in_score;
    logic [15:0]        in_y;
    logic [SIGMOID_TABLE_BITS-1:0] tidx;
    logic [ADDR_W-1:0]  addr;
    logic [63:0]        grad_rd;
    logic [63:0]        curv_rd;
    logic signed [64:0] gsum;
    logic [63:0]        hsum;
    logic signed [63:0] grad_next;
    logic [63:0]        curv_next;
    logic               ram_we;
    logic [63:0]        grad_wd;
    logic [63:0]        curv_wd;
    logic signed [16:0] s_minus_y;
    logic [31:0]        hprod;
    logic signed [31:0] pprod;
    logic               out_load;
    div_req_t           dreq;
    div_rsp_t           drsp;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = state_reg == S_IDLE;
    assign in_tgt   = s_tdata[2:0];
    assign in_score = s_tdata[18:3];
    assign in_y     = s_tdata[34:19];
    assign tidx     = {~in_score[15], in_score[14:16-SIGMOID_TABLE_BITS]};
    assign addr     = ADDR_W'(tgt_reg);

    assign s_minus_y = s_reg - y_reg;
    assign hprod = 32'(s_reg[15:0]) * 32'(17'(ONE_Q15) - s_reg[16:0]);
    assign pprod = p_reg * p_reg;

    assign gsum = {gold_reg[63], gold_reg} + 65'(gterm_reg);
    assign hsum = hold_reg + 64'(hterm_reg);
    assign grad_next = (gsum > SUM_MAX) ? SUM_MAX[63:0]
                     : ((gsum < SUM_MIN) ? SUM_MIN[63:0] : gsum[63:0]);
    assign curv_next = hsum[63] ? SUM_MAX[63:0] : hsum;

    assign ram_we  = (state_reg == S_ACC) && tgt_ok_reg;
    assign grad_wd = last_reg ? 64'd0 : grad_next;
    assign curv_wd = last_reg ? 64'd0 : curv_next;

    assign dreq.start = ram_we && last_reg;
    assign dreq.grad  = grad_next;
    assign dreq.curv  = curv_next[62:0];

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    lln_ram #(.WIDTH(SUM_W), .DEPTH(TARGET_COUNT)) u_grad_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (grad_wd),
        .re    (accept),
        .raddr (ADDR_W'(in_tgt)),
        .rdata (grad_rd)
    );

    lln_ram #(.WIDTH(SUM_W), .DEPTH(TARGET_COUNT)) u_curv_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (curv_wd),
        .re    (accept),
        .raddr (ADDR_W'(in_tgt)),
        .rdata (curv_rd)
    );

    lln_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        tgt_reg    <= in_tgt;
                        last_reg   <= s_tlast;
                        tgt_ok_reg <= {1'b0, in_tgt} < (TGT_W + 1)'(TARGET_COUNT);
                        s_reg      <= signed'({1'b0, SIG_TABLE[tidx]});
                        y_reg      <= (in_y > 16'(ONE_Q15)) ? 17'sd32768
                                                            : signed'({1'b0, in_y});
                        p_reg      <= signed'(s_tdata[50:35]);
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    gold_reg  <= valid_reg[addr] ? signed'(grad_rd) : 64'sd0;
                    hold_reg  <= valid_reg[addr] ? curv_rd : 64'd0;
                    gterm_reg <= s_minus_y * p_reg;
                    pp_reg    <= pprod[30:0];
                    hs_reg    <= hprod[29:15];
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    hterm_reg <= 46'(hs_reg) * 46'(pp_reg);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    rate_reg   <= '0;
                    rvalid_reg <= 1'b0;
                    if (ram_we)
                    begin
                        valid_reg[addr] <= 1'b1;
                    end
                    state_reg <= dreq.start ? S_DIV : S_OUT;
                end
                S_DIV:
                begin
                    if (drsp.done)
                    begin
                        rate_reg   <= drsp.rate;
                        rvalid_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        res_out_reg    <= 17'(y_reg - s_reg);
                        tgt_out_reg    <= tgt_reg;
                        rvalid_out_reg <= rvalid_reg;
                        rate_out_reg   <= rate_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, rate_out_reg, tgt_out_reg, res_out_reg};
    assign m_tuser  = rvalid_out_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == S_DIV)
        else $error("divider result outside the divide state");
    a_we_in_acc: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_ACC)
        else $error("sum write outside the accumulate state");
    a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[51:20] == 32'd0)
        else $error("step nonzero without rate_valid");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && last_reg |-> grad_wd == 64'd0 && curv_wd == 64'd0)
        else $error("last row did not clear the sums");

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the logistic-loss Newton step unit with a scoreboard class.
`timescale 1ns / 1ps

module testbench
    import lln_pkg::*;
();

    localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic [16:0] residual;
        logic [2:0]  target;
        logic        rate_valid;
        logic [31:0] update_rate;
    } step_result_t;

    class newton_scoreboard;
        logic [15:0] sigmoid_lut [TABLE_SIZE];
        longint grad_acc [TARGET_COUNT];
        longint unsigned curv_acc [TARGET_COUNT];
        step_result_t pending_results [$];
        int errors;

        function new();
            longint unsigned e1;
            longint unsigned r;
            longint unsigned den;
            longint unsigned sp;
            int mid;
            int mag;
            e1 = exp_neg(Q30_ONE);
            for (int t = 0; t < TABLE_SIZE; t++)
            begin
                mid = ((2 * t + 1) << (15 - SIGMOID_TABLE_BITS)) - 32768;
                mag = (mid < 0) ? -mid : mid;
                r = exp_neg(longint'(mag & 4095) << 18);
                for (int i = 0; i < (mag >> 12); i++)
                begin
                    r = (r * e1) >> 30;
                end
                den = Q30_ONE + r;
                sp = ((64'd1 << 45) + (den >> 1)) / den;
                sigmoid_lut[t] = (mid > 0) ? sp[15:0] : 16'(64'd32768 - sp);
            end
            for (int i = 0; i < TARGET_COUNT; i++)
            begin
                grad_acc[i] = 0;
                curv_acc[i] = 0;
            end
            errors = 0;
        endfunction

        function automatic longint unsigned exp_neg(longint unsigned y);
            longint sum;
            longint unsigned term;
            sum = Q30_ONE;
            term = Q30_ONE;
            for (int k = 1; k <= 20; k++)
            begin
                term = ((term * y) >> 30) / k;
                if (k % 2 == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            return (sum < 0) ? 0 : longint'(sum);
        endfunction

        function automatic logic [31:0] newton_rate(longint g, longint unsigned h);
            longint unsigned mag;
            longint unsigned quo;
            longint unsigned rem;
            longint unsigned frac;
            if (h == 0)
            begin
                return 32'd0;
            end
            mag = (g < 0) ? -g : g;
            quo = mag / h;
            rem = mag % h;
            frac = 0;
            if (quo >= 8)
            begin
                return (g > 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            for (int i = 0; i < 28; i++)
            begin
                rem = rem << 1;
                frac = frac << 1;
                if (rem >= h)
                begin
                    rem = rem - h;
                    frac = frac | 1;
                end
            end
            mag = (quo << 28) | frac;
            return (g > 0) ? -mag[31:0] : mag[31:0];
        endfunction

        function void note_row(logic [2:0] tgt, logic [15:0] score, logic [15:0] y_in,
                               logic signed [15:0] pred, logic last);
            step_result_t exp_res;
            int y;
            int s;
            longint gterm;
            longint unsigned hterm;
            longint unsigned hs;
            y = (y_in > 16'd32768) ? 32768 : int'(y_in);
            s = sigmoid_lut[(score ^ 16'h8000) >> (16 - SIGMOID_TABLE_BITS)];
            exp_res.residual = 17'(y - s);
            exp_res.target = tgt;
            exp_res.rate_valid = 1'b0;
            exp_res.update_rate = 32'd0;
            gterm = longint'(s - y) * longint'(pred);
            hs = (longint'(s) * longint'(32768 - s)) >> 15;
            hterm = hs * longint'(longint'(pred) * longint'(pred));
            if (gterm > 0 && grad_acc[tgt] > SAT_MAX - gterm)
            begin
                grad_acc[tgt] = SAT_MAX;
            end
            else if (gterm < 0 && grad_acc[tgt] < -SAT_MAX - gterm)
            begin
                grad_acc[tgt] = -SAT_MAX;
            end
            else
            begin
                grad_acc[tgt] = grad_acc[tgt] + gterm;
            end
            if (curv_acc[tgt] > longint'(SAT_MAX) - hterm)
            begin
                curv_acc[tgt] = SAT_MAX;
            end
            else
            begin
                curv_acc[tgt] = curv_acc[tgt] + hterm;
            end
            if (last)
            begin
                exp_res.update_rate = newton_rate(grad_acc[tgt], curv_acc[tgt]);
                exp_res.rate_valid = 1'b1;
                grad_acc[tgt] = 0;
                curv_acc[tgt] = 0;
            end
            pending_results.push_back(exp_res);
        endfunction

        function void check_result(logic [55:0] data, logic user);
            step_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: data %h", data);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (data[16:0] !== exp_res.residual)
            begin
                $error("residual expected %h actual %h", exp_res.residual, data[16:0]);
                errors++;
            end
            if (data[19:17] !== exp_res.target)
            begin
                $error("result_target expected %0d actual %0d", exp_res.target, data[19:17]);
                errors++;
            end
            if (user !== exp_res.rate_valid)
            begin
                $error("rate_valid expected %b actual %b", exp_res.rate_valid, user);
                errors++;
            end
            if (data[51:20] !== exp_res.update_rate)
            begin
                $error("update_rate expected %h actual %h", exp_res.update_rate, data[51:20]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;

    newton_scoreboard sb;
    bit hold_request;
    bit no_idle;
    int cycle_count;

    logistic_loss_newton_step_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_row(logic [2:0] tgt, logic [15:0] score, logic [15:0] y,
                            logic [15:0] pred, logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, pred, y, score, tgt};
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        sb.note_row(tgt, score, y, pred, last);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                stall = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser);
        end
    end

    initial
    begin
        logic [2:0] tgt;
        logic [15:0] y;
        logic [15:0] pred;
        int run_len;
        int sent;
        sb = new();
        cycle_count = 0;
        hold_request = 1'b0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero curvature on a fresh target, then the extremes of each field.
        send_row(3'd0, 16'h0000, 16'd0, 16'h0000, 1'b1);
        send_row(3'd1, 16'h8000, 16'd0, 16'h8000, 1'b0);
        send_row(3'd1, 16'h7FFF, 16'd32768, 16'h7FFF, 1'b0);
        send_row(3'd1, 16'hFFFF, 16'd65535, 16'h0001, 1'b0);
        send_row(3'd1, 16'h0001, 16'd32769, 16'hFFFF, 1'b1);
        send_row(3'd7, 16'h1234, 16'd16384, 16'h1000, 1'b0);
        send_row(3'd7, 16'hEDCC, 16'd8000, 16'hF000, 1'b1);
        // Positive and negative step saturation.
        send_row(3'd5, 16'h7FFF, 16'd0, 16'h0001, 1'b1);
        send_row(3'd6, 16'h8000, 16'd32768, 16'h0001, 1'b1);
        send_row(3'd2, 16'h4000, 16'd32768, 16'h7FFF, 1'b0);
        send_row(3'd2, 16'hC000, 16'd0, 16'h8000, 1'b0);
        send_row(3'd2, 16'h0800, 16'd20000, 16'h0400, 1'b1);
        send_row(3'd3, 16'h0000, 16'd16384, 16'h2000, 1'b1);
        send_row(3'd4, 16'hAAAA, 16'h5555, 16'h5555, 1'b1);
        send_row(3'd4, 16'h5555, 16'hAAAA, 16'hAAAA, 1'b1);
        wait_drained();

        sent = 0;
        while (sent < 1100)
        begin
            tgt = 3'($urandom_range(0, 7));
            run_len = $urandom_range(1, 12);
            for (int i = 0; i < run_len; i++)
            begin
                no_idle = (sent >= 600 && sent < 700);
                if (sent == 300)
                begin
                    hold_request = 1'b1;
                end
                if (sent == 850)
                begin
                    wait_drained();
                end
                case ($urandom_range(0, 9))
                    0: y = 16'($urandom);
                    1: y = 16'd32768;
                    2: y = 16'd0;
                    default: y = 16'($urandom_range(0, 32768));
                endcase
                pred = ($urandom_range(0, 3) == 0) ? 16'($signed($urandom_range(0, 64)) - 32)
                                                   : 16'($urandom);
                send_row(($urandom_range(0, 9) == 0) ? 3'($urandom) : tgt, 16'($urandom), y,
                         pred, (i == run_len - 1) || ($urandom_range(0, 15) == 0));
                sent++;
            end
        end
        wait_drained();
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> logistic_loss_newton_step_unit.f
hw/rtl/lln_pkg.sv
hw/rtl/lln_ram.sv
hw/rtl/lln_div.sv
hw/rtl/logistic_loss_newton_step_unit.sv
bench/testbench.sv
